// ===== design/prim_minimum_spanning_tree_macros.svh =====
// Assertion macros for the minimum spanning tree block.
// Included by the top level; depends on nothing else.
`ifndef PRIM_MINIMUM_SPANNING_TREE_MACROS_SVH
`define PRIM_MINIMUM_SPANNING_TREE_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define PMST_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pmst assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define PMST_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pmst forbidden condition seen");

`else

`define PMST_ASSERT(label, clk, rst_n, prop)
`define PMST_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== design/pmst_pkg.sv =====
// Shared types and constants for the minimum spanning tree block.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none

package pmst_pkg;

    // Fixed widths of the channel fields and the configuration register.
    localparam int VERTEX_W = 4;
    localparam int WEIGHT_W = 15;
    localparam int COUNT_W  = 5;

    // Weights at or above this value mean that there is no edge.
    localparam int NO_EDGE = 30000;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

    // Control part of the search token that moves along the cell chain.
    typedef struct packed {
        logic valid;   // token present at this cell
        logic init;    // first pass of a run: load the row of vertex 0
        logic found;   // a candidate below NO_EDGE has been seen
    } t_tok_ctl;

endpackage

`default_nettype wire

// ===== design/pmst_ifs.sv =====
// Channel interfaces for matrix entry beats and tree result beats.
// Depends on pmst_pkg for the field widths.
`default_nettype none

interface pmst_in_if;
    logic                           valid;
    logic                           ready;
    logic [pmst_pkg::VERTEX_W-1:0]  row_vertex;
    logic [pmst_pkg::VERTEX_W-1:0]  col_vertex;
    logic [pmst_pkg::WEIGHT_W-1:0]  edge_weight;
    logic                           last_entry;

    modport source (output valid, row_vertex, col_vertex, edge_weight, last_entry,
                    input ready);
    modport sink   (input valid, row_vertex, col_vertex, edge_weight, last_entry,
                    output ready);
endinterface

interface pmst_out_if;
    logic                           valid;
    logic                           ready;
    logic [pmst_pkg::VERTEX_W-1:0]  tree_vertex;
    logic [pmst_pkg::VERTEX_W-1:0]  parent_vertex;
    logic [pmst_pkg::WEIGHT_W-1:0]  joining_weight;
    logic                           unreachable;
    logic                           last_result;

    modport source (output valid, tree_vertex, parent_vertex, joining_weight,
                           unreachable, last_result,
                    input ready);
    modport sink   (input valid, tree_vertex, parent_vertex, joining_weight,
                          unreachable, last_result,
                    output ready);
endinterface

`default_nettype wire

// ===== design/pmst_cell.sv =====
// One vertex cell: holds the best joining weight, parent and tree flag of its
// vertex, relaxes against the broadcast matrix word and passes the running
// minimum on to the next cell. Depends on pmst_pkg.
`default_nettype none

module pmst_cell #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 15,
    parameter int IDX          = 0
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire  [$clog2(MAX_VERTICES+1)-1:0]            i_n,
    input  wire  [WEIGHT_BITS-1:0]                       i_rd_data,
    input  pmst_pkg::t_tok_ctl                           i_ctl,
    input  wire  [$clog2(MAX_VERTICES)-1:0]              i_pick,
    input  wire  [((WEIGHT_BITS > 15) ? WEIGHT_BITS : 15)-1:0] i_min_w,
    input  wire  [$clog2(MAX_VERTICES)-1:0]              i_min_idx,
    input  wire  [$clog2(MAX_VERTICES)-1:0]              i_min_par,
    output pmst_pkg::t_tok_ctl                           o_ctl,
    output logic [$clog2(MAX_VERTICES)-1:0]              o_pick,
    output logic [((WEIGHT_BITS > 15) ? WEIGHT_BITS : 15)-1:0] o_min_w,
    output logic [$clog2(MAX_VERTICES)-1:0]              o_min_idx,
    output logic [$clog2(MAX_VERTICES)-1:0]              o_min_par
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (WEIGHT_BITS > 15) ? WEIGHT_BITS : 15;

    localparam logic [VW-1:0] IDX_V = VW'(IDX);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [WEIGHT_BITS-1:0] r_best;
    logic [VW-1:0]          r_parent;
    logic                   r_in_tree;

    logic [WEIGHT_BITS-1:0] n_best;
    logic [VW-1:0]          n_parent;
    logic                   n_in_tree;

    pmst_pkg::t_tok_ctl     r_ctl;
    logic [VW-1:0]          r_pick;
    logic [CMP_W-1:0]       r_min_w;
    logic [VW-1:0]          r_min_idx;
    logic [VW-1:0]          r_min_par;

    pmst_pkg::t_tok_ctl     n_ctl;
    logic [CMP_W-1:0]       n_min_w;
    logic [VW-1:0]          n_min_idx;
    logic [VW-1:0]          n_min_par;

    logic                   w_active;

    assign w_active = i_ctl.valid && (IDX_C < i_n);

    // Relax this vertex against the row of the vertex just added.
    always_comb begin
        n_best    = r_best;
        n_parent  = r_parent;
        n_in_tree = r_in_tree;
        if (w_active) begin
            if (i_ctl.init) begin
                n_in_tree = (i_pick == IDX_V);
                n_best    = i_rd_data;
                n_parent  = '0;
            end else if (i_pick == IDX_V) begin
                n_in_tree = 1'b1;
            end else if (!r_in_tree && (i_rd_data < r_best)) begin
                n_best   = i_rd_data;
                n_parent = i_pick;
            end
        end
    end

    // Offer the updated value to the running minimum; strict compare keeps
    // the lowest vertex on a tie, as cells are visited in ascending order.
    always_comb begin
        n_ctl     = i_ctl;
        n_min_w   = i_min_w;
        n_min_idx = i_min_idx;
        n_min_par = i_min_par;
        if (w_active && !n_in_tree && (CMP_W'(n_best) < i_min_w)) begin
            n_ctl.found = 1'b1;
            n_min_w     = CMP_W'(n_best);
            n_min_idx   = IDX_V;
            n_min_par   = n_parent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tree <= 1'b0;
            r_ctl     <= '0;
        end else begin
            r_in_tree <= n_in_tree;
            r_ctl     <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best    <= n_best;
        r_parent  <= n_parent;
        r_pick    <= i_pick;
        r_min_w   <= n_min_w;
        r_min_idx <= n_min_idx;
        r_min_par <= n_min_par;
    end

    assign o_ctl     = r_ctl;
    assign o_pick    = r_pick;
    assign o_min_w   = r_min_w;
    assign o_min_idx = r_min_idx;
    assign o_min_par = r_min_par;

endmodule

`default_nettype wire

// ===== design/prim_minimum_spanning_tree.sv =====
// Loading: one matrix entry beat per cycle while idle; an entry without the last mark
// produces no result. A run produces one result beat per added vertex, or a final
// unreachable beat when no vertex can be joined. Each result waits for the search token
// to walk the chain of MAX_VERTICES cells as the matrix memory streams one word a cycle.
// Reset (synchronous, active low) clears the control state, the tree flags and sets
// the vertex count to 16; the weight matrix holds whatever was last written.
// Depends on pmst_pkg, pmst_ifs, pmst_cell and the assertion macro header.
`default_nettype none

`include "prim_minimum_spanning_tree_macros.svh"

module prim_minimum_spanning_tree #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 15
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [pmst_pkg::COUNT_W-1:0]      i_cfg_wdata,
    pmst_in_if.sink                           i_in,
    pmst_out_if.source                        o_out
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int AW    = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int CMP_W = (WEIGHT_BITS > 15) ? WEIGHT_BITS : 15;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [pmst_pkg::COUNT_W-1:0]    r_vertex_count;
    logic [CW-1:0]                   r_added;
    logic [VW-1:0]                   r_pick;
    logic                            r_init;
    logic                            r_issuing;
    logic                            r_launch;
    logic [VW-1:0]                   r_rd_cnt;
    logic                            r_found;
    logic [VW-1:0]                   r_res_v;
    logic [VW-1:0]                   r_res_p;
    logic [CMP_W-1:0]                r_res_w;

    logic                            r_out_valid;
    logic [pmst_pkg::VERTEX_W-1:0]   r_tree_vertex;
    logic [pmst_pkg::VERTEX_W-1:0]   r_parent_vertex;
    logic [pmst_pkg::WEIGHT_W-1:0]   r_joining_weight;
    logic                            r_unreachable;
    logic                            r_last_result;

    logic [WEIGHT_BITS-1:0]          r_mem [0:DEPTH-1];
    logic [WEIGHT_BITS-1:0]          r_rd_data;

    logic [CW-1:0]                   w_n;
    logic [CW-1:0]                   w_added_next;
    logic                            w_in_beat;
    logic                            w_wr_en;
    logic [AW-1:0]                   w_wr_addr;
    logic [AW-1:0]                   w_rd_addr;
    logic [MAX_VERTICES-1:0]         w_tok_valid;

    pmst_pkg::t_tok_ctl              w_ctl     [0:MAX_VERTICES];
    logic [VW-1:0]                   w_pick    [0:MAX_VERTICES];
    logic [CMP_W-1:0]                w_min_w   [0:MAX_VERTICES];
    logic [VW-1:0]                   w_min_idx [0:MAX_VERTICES];
    logic [VW-1:0]                   w_min_par [0:MAX_VERTICES];

    // Vertex count clamped to the range the array supports.
    always_comb begin
        if (r_vertex_count < pmst_pkg::COUNT_W'(2)) begin
            w_n = CW'(2);
        end else if (32'(r_vertex_count) > MAX_VERTICES) begin
            w_n = CW'(MAX_VERTICES);
        end else begin
            w_n = CW'(r_vertex_count);
        end
    end

    assign w_added_next = r_added + CW'(1);

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in.valid && i_in.ready;
    assign w_wr_en    = w_in_beat
                        && (32'(i_in.row_vertex) < MAX_VERTICES)
                        && (32'(i_in.col_vertex) < MAX_VERTICES);
    assign w_wr_addr  = AW'(VW'(i_in.row_vertex)) * AW'(MAX_VERTICES)
                        + AW'(VW'(i_in.col_vertex));
    assign w_rd_addr  = AW'(r_pick) * AW'(MAX_VERTICES) + AW'(r_rd_cnt);

    // Weight matrix: one write port for loading, one registered read port that
    // streams the row of the vertex just added, one column per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= WEIGHT_BITS'(i_in.edge_weight);
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // The token enters cell 0 together with the first read word.
    assign w_ctl[0]     = '{valid: r_launch, init: r_init, found: 1'b0};
    assign w_pick[0]    = r_pick;
    assign w_min_w[0]   = CMP_W'(pmst_pkg::NO_EDGE);
    assign w_min_idx[0] = '0;
    assign w_min_par[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_VERTICES; g++) begin : g_cell
            pmst_cell #(
                .MAX_VERTICES (MAX_VERTICES),
                .WEIGHT_BITS  (WEIGHT_BITS),
                .IDX          (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_n       (w_n),
                .i_rd_data (r_rd_data),
                .i_ctl     (w_ctl[g]),
                .i_pick    (w_pick[g]),
                .i_min_w   (w_min_w[g]),
                .i_min_idx (w_min_idx[g]),
                .i_min_par (w_min_par[g]),
                .o_ctl     (w_ctl[g+1]),
                .o_pick    (w_pick[g+1]),
                .o_min_w   (w_min_w[g+1]),
                .o_min_idx (w_min_idx[g+1]),
                .o_min_par (w_min_par[g+1])
            );
            assign w_tok_valid[g] = w_ctl[g+1].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= pmst_pkg::VERTEX_COUNT_RESET;
            r_added        <= '0;
            r_issuing      <= 1'b0;
            r_launch       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_wdata;
            end

            r_launch <= r_issuing && (r_rd_cnt == '0);
            if (r_issuing) begin
                r_rd_cnt <= r_rd_cnt + VW'(1);
                if (r_rd_cnt == VW'(MAX_VERTICES - 1)) begin
                    r_issuing <= 1'b0;
                end
            end

            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_beat && i_in.last_entry) begin
                        r_pick    <= '0;
                        r_init    <= 1'b1;
                        r_added   <= CW'(1);
                        r_issuing <= 1'b1;
                        r_rd_cnt  <= '0;
                        r_state   <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (w_ctl[MAX_VERTICES].valid) begin
                        r_found <= w_ctl[MAX_VERTICES].found;
                        r_res_v <= w_min_idx[MAX_VERTICES];
                        r_res_p <= w_min_par[MAX_VERTICES];
                        r_res_w <= w_min_w[MAX_VERTICES];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // Wait until the output register is free or being taken.
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        if (!r_found) begin
                            r_tree_vertex    <= '0;
                            r_parent_vertex  <= '0;
                            r_joining_weight <= '0;
                            r_unreachable    <= 1'b1;
                            r_last_result    <= 1'b1;
                            r_state          <= S_IDLE;
                        end else begin
                            r_added          <= w_added_next;
                            r_tree_vertex    <= pmst_pkg::VERTEX_W'(r_res_v);
                            r_parent_vertex  <= pmst_pkg::VERTEX_W'(r_res_p);
                            r_joining_weight <= pmst_pkg::WEIGHT_W'(r_res_w);
                            r_unreachable    <= 1'b0;
                            r_last_result    <= (w_added_next == w_n);
                            if (w_added_next == w_n) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_pick    <= r_res_v;
                                r_init    <= 1'b0;
                                r_issuing <= 1'b1;
                                r_rd_cnt  <= '0;
                                r_state   <= S_SWEEP;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.tree_vertex    = r_tree_vertex;
    assign o_out.parent_vertex  = r_parent_vertex;
    assign o_out.joining_weight = r_joining_weight;
    assign o_out.unreachable    = r_unreachable;
    assign o_out.last_result    = r_last_result;

    // Only one search token is ever in the chain.
    `PMST_ASSERT(a_one_token, i_clk, i_rst_n, $onehot0(w_tok_valid))

    // Vertex 0 is in the tree from the first pass on, so it is never picked.
    `PMST_ASSERT(a_pick_nonzero, i_clk, i_rst_n,
        (w_ctl[MAX_VERTICES].valid && w_ctl[MAX_VERTICES].found) |->
        (w_min_idx[MAX_VERTICES] != '0))

    // A pass only runs while vertices remain to be added.
    `PMST_ASSERT(a_sweep_count, i_clk, i_rst_n, (r_state == S_SWEEP) |-> (r_added < w_n))

    // Matrix reads are issued only during a pass.
    `PMST_ASSERT_NEVER(a_read_outside, i_clk, i_rst_n, r_issuing && (r_state != S_SWEEP))

endmodule

`default_nettype wire

// ===== verif/prim_minimum_spanning_tree_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for prim_minimum_spanning_tree: loads weight matrices, triggers
// spanning tree runs and compares every result beat with its tree builder or a typed one.
// Depends on pmst_pkg, pmst_ifs and the block itself.

module prim_minimum_spanning_tree_tb;
    import pmst_pkg::*;

    localparam int MAX_V        = 16;
    localparam int WEIGHT_MAX   = 32767;
    localparam int RANDOM_LOADS = 220;
    localparam int SETTLE       = 40;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [VERTEX_W-1:0] row_vertex;
        logic [VERTEX_W-1:0] col_vertex;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                last_entry;
    } entry_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] tree_vertex;
        logic [VERTEX_W-1:0] parent_vertex;
        logic [WEIGHT_W-1:0] joining_weight;
        logic                unreachable;
        logic                last_result;
    } tree_beat_t;

    typedef enum int {STEP_CONFIG, STEP_LOAD, STEP_LOAD_TYPED, STEP_RESULT} step_e;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [COUNT_W-1:0]  i_cfg_wdata;

    pmst_in_if  in_ch ();
    pmst_out_if out_ch ();

    prim_minimum_spanning_tree u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Tree builder state: its own copy of the matrix and of the vertex count.
    logic [WEIGHT_W-1:0] edge_w [MAX_V][MAX_V];
    bit                  loaded [MAX_V][MAX_V];
    logic [COUNT_W-1:0]  span_count;

    tree_beat_t tree_q [$];
    tree_beat_t want_beat;
    int         mismatches  = 0;
    int         random_loads = 0;
    bit         quiet       = 1'b0;
    bit         hold_req    = 1'b0;

    // Directed steps. Load columns: row, col, weight, last. Result columns: vertex,
    // parent, weight, unreachable, last. A typed result precedes the load causing it.
    int dir_steps [28][6] = '{
        '{STEP_CONFIG,     2,  0,     0, 0, 0},
        '{STEP_LOAD,       1,  0, 32767, 0, 0},
        '{STEP_LOAD,       1,  1,     0, 0, 0},
        '{STEP_LOAD,       0,  0,     0, 0, 0},
        '{STEP_RESULT,     1,  0, 29999, 0, 1},
        '{STEP_LOAD_TYPED, 0,  1, 29999, 1, 0},
        '{STEP_RESULT,     0,  0,     0, 1, 1},
        '{STEP_LOAD_TYPED, 0,  1, 30000, 1, 0},
        '{STEP_LOAD,      15, 15, 32767, 0, 0},
        '{STEP_RESULT,     1,  0,     0, 0, 1},
        '{STEP_LOAD_TYPED, 0,  1,     0, 1, 0},
        '{STEP_CONFIG,     0,  0,     0, 0, 0},
        '{STEP_RESULT,     0,  0,     0, 1, 1},
        '{STEP_LOAD_TYPED, 0,  1, 32767, 1, 0},
        '{STEP_CONFIG,     1,  0,     0, 0, 0},
        '{STEP_LOAD,       0,  1, 12345, 1, 0},
        '{STEP_CONFIG,     3,  0,     0, 0, 0},
        '{STEP_LOAD,       0,  0,     0, 0, 0},
        '{STEP_LOAD,       0,  1,     5, 0, 0},
        '{STEP_LOAD,       0,  2,     5, 0, 0},
        '{STEP_LOAD,       1,  0,     7, 0, 0},
        '{STEP_LOAD,       1,  1,     0, 0, 0},
        '{STEP_LOAD,       1,  2,     5, 0, 0},
        '{STEP_LOAD,       2,  0,     9, 0, 0},
        '{STEP_LOAD,       2,  1,     4, 0, 0},
        '{STEP_RESULT,     1,  0,     5, 0, 0},
        '{STEP_RESULT,     2,  0,     5, 0, 1},
        '{STEP_LOAD_TYPED, 2,  2, 16384, 1, 0}
    };

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int tree_span();
        if (span_count < 2) begin
            return 2;
        end
        if (span_count > MAX_V) begin
            return MAX_V;
        end
        return span_count;
    endfunction

    // Stores the entry and, on the last mark, grows the tree from vertex 0.
    function automatic void grow_tree(entry_t e, bit keep);
        logic [WEIGHT_W-1:0] best_w [MAX_V];
        logic [VERTEX_W-1:0] best_p [MAX_V];
        bit                  joined [MAX_V];
        logic [WEIGHT_W-1:0] pick_w;
        tree_beat_t          beat;
        int                  n, added, pick, i;
        bit                  found;

        edge_w[e.row_vertex][e.col_vertex] = e.edge_weight;
        loaded[e.row_vertex][e.col_vertex] = 1'b1;
        if (!e.last_entry) begin
            return;
        end
        n = tree_span();
        for (i = 0; i < MAX_V; i++) begin
            best_w[i] = (i < n) ? edge_w[0][i] : '0;
            best_p[i] = '0;
            joined[i] = 1'b0;
        end
        joined[0] = 1'b1;
        added = 1;
        while (added < n) begin
            found  = 1'b0;
            pick   = 0;
            pick_w = NO_EDGE;
            // Strictly lighter only, so a tie keeps the lowest vertex number.
            for (i = 1; i < n; i++) begin
                if (!joined[i] && best_w[i] < pick_w) begin
                    pick_w = best_w[i];
                    pick   = i;
                    found  = 1'b1;
                end
            end
            if (!found) begin
                beat = '{tree_vertex: '0, parent_vertex: '0, joining_weight: '0,
                         unreachable: 1'b1, last_result: 1'b1};
                if (keep) begin
                    tree_q.push_back(beat);
                end
                return;
            end
            joined[pick] = 1'b1;
            added++;
            beat = '{tree_vertex: pick, parent_vertex: best_p[pick], joining_weight: pick_w,
                     unreachable: 1'b0, last_result: (added == n)};
            if (keep) begin
                tree_q.push_back(beat);
            end
            for (i = 0; i < n; i++) begin
                if (!joined[i] && edge_w[pick][i] < best_w[i]) begin
                    best_w[i] = edge_w[pick][i];
                    best_p[i] = pick;
                end
            end
        end
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return $urandom_range(NO_EDGE, WEIGHT_MAX);
            1: return '0;
            2: return NO_EDGE - 1;
            3: return $urandom_range(0, NO_EDGE - 1);
            // Narrow range so that equal candidates turn up often.
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    task automatic send_entry(entry_t e, bit keep);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        grow_tree(e, keep);
        in_ch.valid       <= 1'b1;
        in_ch.row_vertex  <= e.row_vertex;
        in_ch.col_vertex  <= e.col_vertex;
        in_ch.edge_weight <= e.edge_weight;
        in_ch.last_entry  <= e.last_entry;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (tree_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(logic [COUNT_W-1:0] value);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        span_count   = value;
    endtask

    task automatic run_random_phase(int phase);
        entry_t batch [$];
        entry_t e, tmp;
        bit     member [MAX_V];
        bit     full;
        int     n, i, j;

        quiet = (random_loads >= RANDOM_LOADS - 40) || ($urandom_range(0, 4) == 0);
        if (phase == 2) begin
            write_vertex_count(5'd31);
        end else if (phase == 6) begin
            write_vertex_count(5'd16);
        end else if (phase != 3 && (phase == 0 || $urandom_range(0, 2) == 0)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: write_vertex_count($urandom_range(2, 6));
                6:                write_vertex_count($urandom_range(7, 15));
                7:                write_vertex_count(5'd16);
                8:                write_vertex_count($urandom_range(17, 31));
                default:          write_vertex_count($urandom_range(0, 1));
            endcase
        end
        // Sender waits here until every result of the earlier runs has arrived.
        if (phase == 4) begin
            drain_results();
        end
        n = tree_span();
        full = 1'b1;
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
                if (!loaded[i][j]) begin
                    full = 1'b0;
                end
            end
        end

        if (full && phase != 2 && $urandom_range(0, 3) == 0) begin
            // Rerun over a mostly stale matrix with only a few entries reloaded.
            for (i = 0; i < n; i++) begin
                for (j = 0; j < n; j++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        batch.push_back('{i, j, rand_weight(), 1'b0});
                    end
                end
            end
            if (batch.size() == 0) begin
                batch.push_back('{$urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                  rand_weight(), 1'b0});
            end
        end else begin
            // Only rows of member vertices are read by a run, so only those are loaded
            // in full; edges out to non-members are absent, keeping the run inside.
            for (i = 0; i < MAX_V; i++) begin
                member[i] = (i == 0) ||
                            (i < n && n <= 8 && $urandom_range(0, 3) != 0) ||
                            (n > 8 && i == n - 1);
            end
            if (n > 8) begin
                repeat (2) member[$urandom_range(1, n - 1)] = 1'b1;
            end
            for (i = 0; i < n; i++) begin
                if (member[i]) begin
                    for (j = 0; j < n; j++) begin
                        e = '{i, j, member[j] ? rand_weight()
                                              : $urandom_range(NO_EDGE, WEIGHT_MAX), 1'b0};
                        batch.push_back(e);
                    end
                end
            end
            for (i = batch.size() - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = batch[i];
                batch[i] = batch[j];
                batch[j] = tmp;
            end
            repeat ($urandom_range(0, 3)) begin
                e = '{$urandom_range(0, MAX_V - 1), $urandom_range(0, MAX_V - 1),
                      $urandom_range(0, WEIGHT_MAX), 1'b0};
                if (!(member[e.row_vertex] && e.col_vertex < n)) begin
                    batch.insert($urandom_range(0, batch.size()), e);
                end
            end
        end
        batch[batch.size() - 1].last_entry = 1'b1;

        // Receiver stops for a long stretch while this large run and the next load.
        if (phase == 2) begin
            hold_req = 1'b1;
        end
        foreach (batch[k]) begin
            send_entry(batch[k], 1'b1);
            random_loads++;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.row_vertex  = '0;
        in_ch.col_vertex  = '0;
        in_ch.edge_weight = '0;
        in_ch.last_entry  = 1'b0;
        span_count        = VERTEX_COUNT_RESET;
        foreach (loaded[r, c]) begin
            loaded[r][c] = 1'b0;
            edge_w[r][c] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int s = 0; s < 28; s++) begin
            case (dir_steps[s][0])
                STEP_CONFIG: write_vertex_count(dir_steps[s][1]);
                STEP_RESULT: tree_q.push_back('{dir_steps[s][1], dir_steps[s][2],
                                                dir_steps[s][3], dir_steps[s][4],
                                                dir_steps[s][5]});
                default: send_entry('{dir_steps[s][1], dir_steps[s][2], dir_steps[s][3],
                                      dir_steps[s][4]},
                                    dir_steps[s][0] != STEP_LOAD_TYPED);
            endcase
        end

        for (int phase = 0; random_loads < RANDOM_LOADS; phase++) begin
            run_random_phase(phase);
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result side back-pressure: one long hold on request, random short stalls unless quiet.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (tree_q.size() == 0) begin
                $error("result beat with nothing expected: tree_vertex %0d",
                       out_ch.tree_vertex);
                mismatches++;
            end else begin
                want_beat = tree_q.pop_front();
                if (out_ch.tree_vertex !== want_beat.tree_vertex) begin
                    $error("tree_vertex: expected %0d, got %0d",
                           want_beat.tree_vertex, out_ch.tree_vertex);
                    mismatches++;
                end
                if (out_ch.parent_vertex !== want_beat.parent_vertex) begin
                    $error("parent_vertex: expected %0d, got %0d",
                           want_beat.parent_vertex, out_ch.parent_vertex);
                    mismatches++;
                end
                if (out_ch.joining_weight !== want_beat.joining_weight) begin
                    $error("joining_weight: expected %0d, got %0d",
                           want_beat.joining_weight, out_ch.joining_weight);
                    mismatches++;
                end
                if (out_ch.unreachable !== want_beat.unreachable) begin
                    $error("unreachable: expected %0d, got %0d",
                           want_beat.unreachable, out_ch.unreachable);
                    mismatches++;
                end
                if (out_ch.last_result !== want_beat.last_result) begin
                    $error("last_result: expected %0d, got %0d",
                           want_beat.last_result, out_ch.last_result);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
